// ===== rtl/tmpg_pkg.sv =====
// shared types, constants and table functions of the torus mesh point generator
`default_nettype none

package tmpg_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HOLE_RADIUS = 2'd0,
    REG_TUBE_RADIUS = 2'd1,
    REG_SEGMENTS    = 2'd2
  } tmpg_reg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned SEG_REG_W  = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned POS_W      = 19;
  localparam int unsigned CORNER_W   = 17;

  // sine magnitude in q0.15, fraction bits rounded off after each product
  localparam int unsigned SIN_W   = 15;
  localparam int unsigned FRAC_SH = 15;

  localparam logic [RADIUS_W-1:0] HOLE_RESET = 16'd256;
  localparam logic [RADIUS_W-1:0] TUBE_RESET = 16'd128;
  localparam int unsigned         SEG_RESET  = 16;

  // odd taylor terms of sin(pi/2*x) in q30
  localparam longint SIN_C1 = 64'sd1686629713;
  localparam longint SIN_C3 = -64'sd693598668;
  localparam longint SIN_C5 = 64'sd85569306;
  localparam longint SIN_C7 = -64'sd5026994;
  localparam longint SIN_C9 = 64'sd172273;
  localparam longint SIN_MAX = 64'sd32767;
  localparam longint SIN_HALF = 64'sd16384;

  localparam logic [POS_W:0] POS_MAG_MAX = {2'b00, {(POS_W-1){1'b1}}};

  // side data that rides along with an item
  typedef struct packed {
    logic                bad;
    logic [CORNER_W-1:0] ca;
    logic [CORNER_W-1:0] cb;
    logic [CORNER_W-1:0] cc;
    logic [CORNER_W-1:0] cd;
  } tmpg_side_t;

  // signed a*b/2^30, truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    logic   neg;
    longint ua;
    longint ub;
    longint m;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    m   = (ua * ub) >>> 30;
    return neg ? -m : m;
  endfunction

  // quarter wave sine entry j, position inside the quadrant is j << sh in q30
  function automatic logic [SIN_W-1:0] sin_entry(input int j, input int sh);
    longint x;
    longint x2;
    longint p;
    longint s;
    x  = longint'(j) << sh;
    x2 = mul_q30(x, x);
    p  = SIN_C9;
    p  = SIN_C7 + mul_q30(p, x2);
    p  = SIN_C5 + mul_q30(p, x2);
    p  = SIN_C3 + mul_q30(p, x2);
    p  = SIN_C1 + mul_q30(p, x2);
    s  = mul_q30(p, x);
    if (s < 0) begin
      s = 0;
    end
    s = (s + SIN_HALF) >>> 15;
    if (s > SIN_MAX) begin
      s = SIN_MAX;
    end
    return SIN_W'(s);
  endfunction

  // apply sign to a magnitude and clamp to the signed position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic neg,
                                                      input logic [POS_W:0] mag);
    logic [POS_W:0] lim;
    logic [POS_W:0] m;
    lim = neg ? POS_MAG_MAX + 1'b1 : POS_MAG_MAX;
    m   = (mag > lim) ? lim : mag;
    return neg ? POS_W'(-m) : POS_W'(m);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/torus_mesh_point_generator.sv =====
// torus mesh point generator: vertex position and quad corner indices per grid point
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  ------------------------------
//  command   start_i, busy_o, ring_index_i, slice_index_i  taken when start_i & !busy_o
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,        written when valid & ready
//            cfg_data_i
//  result    done_o, pos_*_o, corner_*_o, index_invalid_o  one cycle strobe on done_o
//
// a new item can be taken every cycle; busy_o stays low since nothing downstream stalls
// an item passes the entry registers, the bit per stage angle divider, table read, tube
// products, radius sum, radius times ring angle and output registers before done_o rises
// reset clears the valid bits and loads hole 1.0, tube 0.5, min(16, MAX_SEGMENTS) segments
// TRIG_TABLE_DEPTH must be a power of two (not checked); only a quarter sine wave is kept
`default_nettype none

module torus_mesh_point_generator #(
  parameter int unsigned MAX_SEGMENTS     = 256,
  parameter int unsigned TRIG_TABLE_DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // command
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [tmpg_pkg::IDX_W-1:0]             ring_index_i,
  input  logic [tmpg_pkg::IDX_W-1:0]             slice_index_i,
  // config writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tmpg_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tmpg_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // result
  output logic                                   done_o,
  output logic signed [tmpg_pkg::POS_W-1:0]      pos_x_o,
  output logic signed [tmpg_pkg::POS_W-1:0]      pos_y_o,
  output logic signed [tmpg_pkg::POS_W-1:0]      pos_z_o,
  output logic [tmpg_pkg::CORNER_W-1:0]          corner_a_o,
  output logic [tmpg_pkg::CORNER_W-1:0]          corner_b_o,
  output logic [tmpg_pkg::CORNER_W-1:0]          corner_c_o,
  output logic [tmpg_pkg::CORNER_W-1:0]          corner_d_o,
  output logic                                   index_invalid_o
);

  import tmpg_pkg::*;

  // segment count width, index compare width and corner arithmetic width
  localparam int unsigned SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IW    = (SEG_W > IDX_W + 1) ? SEG_W : IDX_W + 1;
  localparam int unsigned CW    = IW + SEG_W + 1;
  // table index bits, quarter wave address bits and quarter depth
  localparam int unsigned L     = $clog2(TRIG_TABLE_DEPTH);
  localparam int unsigned AW    = L - 1;
  localparam int unsigned QD    = TRIG_TABLE_DEPTH / 4;
  localparam int unsigned SEG_RST = (MAX_SEGMENTS < SEG_RESET) ? MAX_SEGMENTS : SEG_RESET;
  // product widths
  localparam int unsigned P1W   = RADIUS_W + SIN_W;
  localparam int unsigned RW    = RADIUS_W + 2;
  localparam int unsigned RCW   = P1W + 1 - FRAC_SH;
  localparam int unsigned P3W   = RW + SIN_W;
  localparam int unsigned XMW   = P3W + 1 - FRAC_SH;
  localparam int unsigned MAG_W = POS_W + 1;

  logic accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  // ---------------------------------------------------------------------------
  // configuration registers, segments clamp to MAX_SEGMENTS on write
  // ---------------------------------------------------------------------------
  logic [RADIUS_W-1:0]  hole_q;
  logic [RADIUS_W-1:0]  tube_q;
  logic [SEG_W-1:0]     seg_q;
  logic [SEG_REG_W-1:0] seg_wr;
  logic [SEG_W-1:0]     seg_d;

  assign seg_wr = cfg_data_i[SEG_REG_W-1:0];
  assign seg_d  = (32'(seg_wr) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : SEG_W'(seg_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_q <= HOLE_RESET;
      tube_q <= TUBE_RESET;
      seg_q  <= SEG_W'(SEG_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tmpg_reg_e'(cfg_index_i))
        REG_HOLE_RADIUS: hole_q <= cfg_data_i[RADIUS_W-1:0];
        REG_TUBE_RADIUS: tube_q <= cfg_data_i[RADIUS_W-1:0];
        REG_SEGMENTS:    seg_q  <= seg_d;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // entry: range check and corner indices (one small multiply per row base)
  // ---------------------------------------------------------------------------
  logic [IW-1:0] ring_x;
  logic [IW-1:0] slice_x;
  logic [IW-1:0] n_x;
  logic [IW-1:0] ring_nx;
  logic [IW-1:0] slice_nx;
  logic [CW-1:0] base0;
  logic [CW-1:0] base1;
  tmpg_side_t    side_d;

  always_comb begin
    ring_x   = IW'(ring_index_i);
    slice_x  = IW'(slice_index_i);
    n_x      = IW'(seg_q);
    // wrap to zero on the last ring or slice
    ring_nx  = (IW'(ring_x + IW'(1)) == n_x) ? '0 : IW'(ring_x + IW'(1));
    slice_nx = (IW'(slice_x + IW'(1)) == n_x) ? '0 : IW'(slice_x + IW'(1));
    base0    = CW'(CW'(ring_x) * CW'(seg_q));
    base1    = CW'(CW'(ring_nx) * CW'(seg_q));
    side_d.bad = (ring_x >= n_x) | (slice_x >= n_x);
    side_d.ca  = CORNER_W'(base0 + CW'(slice_x) + CW'(1));
    side_d.cb  = CORNER_W'(base0 + CW'(slice_nx) + CW'(1));
    side_d.cc  = CORNER_W'(base1 + CW'(slice_nx) + CW'(1));
    side_d.cd  = CORNER_W'(base1 + CW'(slice_x) + CW'(1));
  end

  // ---------------------------------------------------------------------------
  // angle divider: k = floor(idx * depth / n), one quotient bit per stage
  // remainder starts at idx, which is below n for every valid item
  // ---------------------------------------------------------------------------
  logic [L:0]       dv_q;
  logic [SEG_W-1:0] rr_q [L+1];
  logic [SEG_W-1:0] rs_q [L+1];
  logic [L-1:0]     kr_q [L+1];
  logic [L-1:0]     ks_q [L+1];
  tmpg_side_t       sd_q [L+1];
  logic [SEG_W-1:0] rr_d [L];
  logic [SEG_W-1:0] rs_d [L];
  logic [L-1:0]     kr_d [L];
  logic [L-1:0]     ks_d [L];

  always_comb begin
    logic [SEG_W:0] shr;
    logic [SEG_W:0] shs;
    logic           ger;
    logic           ges;
    for (int i = 0; i < L; i++) begin
      shr     = {rr_q[i], 1'b0};
      shs     = {rs_q[i], 1'b0};
      ger     = shr >= {1'b0, seg_q};
      ges     = shs >= {1'b0, seg_q};
      rr_d[i] = ger ? SEG_W'(shr - {1'b0, seg_q}) : SEG_W'(shr);
      rs_d[i] = ges ? SEG_W'(shs - {1'b0, seg_q}) : SEG_W'(shs);
      kr_d[i] = {kr_q[i][L-2:0], ger};
      ks_d[i] = {ks_q[i][L-2:0], ges};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[L-1:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q[0] <= SEG_W'(ring_index_i);
    rs_q[0] <= SEG_W'(slice_index_i);
    kr_q[0] <= '0;
    ks_q[0] <= '0;
    sd_q[0] <= side_d;
    for (int i = 0; i < L; i++) begin
      rr_q[i+1] <= rr_d[i];
      rs_q[i+1] <= rs_d[i];
      kr_q[i+1] <= kr_d[i];
      ks_q[i+1] <= ks_d[i];
      sd_q[i+1] <= sd_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // quarter wave sine table, entries 0..depth/4 inclusive
  // odd quadrants read mirrored, quadrants 2 and 3 negate; cosine is one
  // quadrant ahead of sine at the same position
  // ---------------------------------------------------------------------------
  logic [SIN_W-1:0] sin_rom [QD+1];

  for (genvar g = 0; g <= QD; g++) begin : g_rom
    localparam logic [SIN_W-1:0] ENTRY = sin_entry(g, 32 - L);
    assign sin_rom[g] = ENTRY;
  end

  logic [1:0]    qp;
  logic [1:0]    qpc;
  logic [1:0]    qt;
  logic [1:0]    qtc;
  logic [AW-1:0] dir_p;
  logic [AW-1:0] mir_p;
  logic [AW-1:0] dir_t;
  logic [AW-1:0] mir_t;
  logic [AW-1:0] a_sp;
  logic [AW-1:0] a_cp;
  logic [AW-1:0] a_st;
  logic [AW-1:0] a_ct;

  always_comb begin
    qp    = kr_q[L][L-1:L-2];
    qt    = ks_q[L][L-1:L-2];
    qpc   = qp + 2'd1;
    qtc   = qt + 2'd1;
    dir_p = AW'(kr_q[L][L-3:0]);
    dir_t = AW'(ks_q[L][L-3:0]);
    mir_p = AW'(QD) - dir_p;
    mir_t = AW'(QD) - dir_t;
    a_sp  = qp[0]  ? mir_p : dir_p;
    a_cp  = qpc[0] ? mir_p : dir_p;
    a_st  = qt[0]  ? mir_t : dir_t;
    a_ct  = qtc[0] ? mir_t : dir_t;
  end

  // table read stage
  logic             tv_q;
  logic [SIN_W-1:0] sp_q;
  logic [SIN_W-1:0] cp_q;
  logic [SIN_W-1:0] st_q;
  logic [SIN_W-1:0] ct_q;
  logic             sp_neg_q;
  logic             cp_neg_q;
  logic             st_neg_q;
  logic             ct_neg_q;
  tmpg_side_t       t_sd_q;

  // tube products stage
  logic             m1v_q;
  logic [P1W-1:0]   p_ct_q;
  logic [P1W-1:0]   p_st_q;
  logic [SIN_W-1:0] m1_sp_q;
  logic [SIN_W-1:0] m1_cp_q;
  logic             m1_sp_neg_q;
  logic             m1_cp_neg_q;
  logic             m1_st_neg_q;
  logic             m1_ct_neg_q;
  tmpg_side_t       m1_sd_q;

  // radius sum stage
  logic             m2v_q;
  logic [RW-1:0]    rad_q;
  logic [RCW-1:0]   y_mag_q;
  logic             m2_y_neg_q;
  logic [SIN_W-1:0] m2_sp_q;
  logic [SIN_W-1:0] m2_cp_q;
  logic             m2_sp_neg_q;
  logic             m2_cp_neg_q;
  tmpg_side_t       m2_sd_q;

  // radius times ring angle stage
  logic             m3v_q;
  logic [P3W-1:0]   px_q;
  logic [P3W-1:0]   pz_q;
  logic [RCW-1:0]   m3_y_mag_q;
  logic             m3_y_neg_q;
  logic             m3_x_neg_q;
  logic             m3_z_neg_q;
  tmpg_side_t       m3_sd_q;

  // output registers
  logic                    done_q;
  logic signed [POS_W-1:0] pos_x_q;
  logic signed [POS_W-1:0] pos_y_q;
  logic signed [POS_W-1:0] pos_z_q;
  logic [CORNER_W-1:0]     corner_a_q;
  logic [CORNER_W-1:0]     corner_b_q;
  logic [CORNER_W-1:0]     corner_c_q;
  logic [CORNER_W-1:0]     corner_d_q;
  logic                    invalid_q;

  // rounding: magnitudes rounded half up, sign applied after, which is
  // half away from zero on the signed value
  logic [P1W:0]   ct_sum;
  logic [P1W:0]   st_sum;
  logic [RCW-1:0] ct_rnd;
  logic [RW-1:0]  rad_base;
  logic [RW-1:0]  rad_d;
  logic [P3W:0]   x_sum;
  logic [P3W:0]   z_sum;
  logic [XMW-1:0] x_mag;
  logic [XMW-1:0] z_mag;

  always_comb begin
    ct_sum   = {1'b0, p_ct_q} + (P1W+1)'(1 << (FRAC_SH - 1));
    st_sum   = {1'b0, p_st_q} + (P1W+1)'(1 << (FRAC_SH - 1));
    ct_rnd   = ct_sum[P1W:FRAC_SH];
    rad_base = RW'(hole_q) + RW'(tube_q);
    // hole + tube - tube*|cos| never drops below hole
    rad_d    = m1_ct_neg_q ? RW'(rad_base - RW'(ct_rnd)) : RW'(rad_base + RW'(ct_rnd));
    x_sum    = {1'b0, px_q} + (P3W+1)'(1 << (FRAC_SH - 1));
    z_sum    = {1'b0, pz_q} + (P3W+1)'(1 << (FRAC_SH - 1));
    x_mag    = x_sum[P3W:FRAC_SH];
    z_mag    = z_sum[P3W:FRAC_SH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q   <= 1'b0;
      m1v_q  <= 1'b0;
      m2v_q  <= 1'b0;
      m3v_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      tv_q   <= dv_q[L];
      m1v_q  <= tv_q;
      m2v_q  <= m1v_q;
      m3v_q  <= m2v_q;
      done_q <= m3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // table read
    sp_q     <= sin_rom[a_sp];
    cp_q     <= sin_rom[a_cp];
    st_q     <= sin_rom[a_st];
    ct_q     <= sin_rom[a_ct];
    sp_neg_q <= qp[1];
    cp_neg_q <= qpc[1];
    st_neg_q <= qt[1];
    ct_neg_q <= qtc[1];
    t_sd_q   <= sd_q[L];
    // tube * cos t and tube * sin t
    p_ct_q      <= P1W'(P1W'(tube_q) * P1W'(ct_q));
    p_st_q      <= P1W'(P1W'(tube_q) * P1W'(st_q));
    m1_sp_q     <= sp_q;
    m1_cp_q     <= cp_q;
    m1_sp_neg_q <= sp_neg_q;
    m1_cp_neg_q <= cp_neg_q;
    m1_st_neg_q <= st_neg_q;
    m1_ct_neg_q <= ct_neg_q;
    m1_sd_q     <= t_sd_q;
    // radius sum and y
    rad_q       <= rad_d;
    y_mag_q     <= st_sum[P1W:FRAC_SH];
    m2_y_neg_q  <= m1_st_neg_q;
    m2_sp_q     <= m1_sp_q;
    m2_cp_q     <= m1_cp_q;
    m2_sp_neg_q <= m1_sp_neg_q;
    m2_cp_neg_q <= m1_cp_neg_q;
    m2_sd_q     <= m1_sd_q;
    // radius * cos p and radius * sin p
    px_q       <= P3W'(P3W'(rad_q) * P3W'(m2_cp_q));
    pz_q       <= P3W'(P3W'(rad_q) * P3W'(m2_sp_q));
    m3_y_mag_q <= y_mag_q;
    m3_y_neg_q <= m2_y_neg_q;
    m3_x_neg_q <= m2_cp_neg_q;
    m3_z_neg_q <= m2_sp_neg_q;
    m3_sd_q    <= m2_sd_q;
    // result, zeroed for an out of range index
    if (m3_sd_q.bad) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      corner_a_q <= '0;
      corner_b_q <= '0;
      corner_c_q <= '0;
      corner_d_q <= '0;
    end else begin
      pos_x_q    <= sat_pos(m3_x_neg_q, MAG_W'(x_mag));
      pos_y_q    <= sat_pos(m3_y_neg_q, MAG_W'(m3_y_mag_q));
      pos_z_q    <= sat_pos(m3_z_neg_q, MAG_W'(z_mag));
      corner_a_q <= m3_sd_q.ca;
      corner_b_q <= m3_sd_q.cb;
      corner_c_q <= m3_sd_q.cc;
      corner_d_q <= m3_sd_q.cd;
    end
    invalid_q <= m3_sd_q.bad;
  end

  assign done_o          = done_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign pos_z_o         = pos_z_q;
  assign corner_a_o      = corner_a_q;
  assign corner_b_o      = corner_b_q;
  assign corner_c_o      = corner_c_q;
  assign corner_d_o      = corner_d_q;
  assign index_invalid_o = invalid_q;

endmodule

`default_nettype wire
